### src/assert_macros.svh
// Assertion macros for the RTL of the heap priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/hpq_pkg.sv
// Types and codes of the binary min-heap priority queue.
`timescale 1ns / 1ps

package hpq_pkg;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 16;
   localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

   typedef struct packed {
      logic                 kind;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [7:0]           count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

### src/binary_min_heap_priority_queue_unit.sv
// Binary min-heap priority queue: one heap RAM walked by a sift sequencer.
// One item at a time: req_stall is high from accept until the result enters the output register.
// Each heap level costs one RAM read, a compare and a write going up, and up to two RAM reads
// (both children come through one port), a compare and a write going down.
// Reset clears the count and the handshake state; the heap RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_min_heap_priority_queue_unit #(
   parameter int CAPACITY = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hpq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hpq_pkg::rsp_type rsp_data
);

   import hpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_DN_CHK,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    count_ff, count_in;
   entry_type        item_ff, item_in;
   entry_type        left_ff, left_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   entry_type        mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [ENTRY_W-1:0] mem_rbits;
   entry_type        mem_rdata;

   logic [AW-1:0]    parent_idx;
   logic [IW-1:0]    left_idx;
   logic [IW-1:0]    right_idx;
   logic [IW-1:0]    count_wide;
   logic [CW-1:0]    count_dec;
   logic             right_ok;
   logic             pick_right;
   entry_type        pick;
   logic             req_accept;
   logic             out_free;

   hpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign mem_rdata  = entry_type'(mem_rbits);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IW'(1);
   assign count_wide = IW'(count_ff);
   assign count_dec  = count_ff - CW'(1);
   assign right_ok   = right_idx < count_wide;
   // Take the right child, if there is one, unless the left one is strictly smaller.
   assign pick_right = right_ok && !(left_ff.key < mem_rdata.key);
   assign pick       = pick_right ? mem_rdata : left_ff;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      item_in      = item_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = item_ff;
      mem_raddr    = '0;

      // Drop the delivered item.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_in = '0;
               res_in.status = STATUS_OK;
               if (req_data.kind == KIND_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     res_in.status = STATUS_FULL;
                     state_in = ST_FIN;
                  end else begin
                     item_in.key     = req_data.key;
                     item_in.payload = req_data.payload;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_EMPTY;
                     state_in = ST_FIN;
                  end else begin
                     // Root read issues on this edge.
                     state_in = ST_RM_ROOT;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end else begin
               mem_raddr = parent_idx;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (item_ff.key < mem_rdata.key) begin
               // Move the parent down into the hole.
               mem_wdata = mem_rdata;
               pos_in    = parent_idx;
               state_in  = ST_UP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_RM_ROOT: begin
            res_in.out_key     = mem_rdata.key;
            res_in.out_payload = mem_rdata.payload;
            mem_raddr = count_dec[AW-1:0];
            count_in  = count_dec;
            state_in  = ST_RM_LAST;
         end
         ST_RM_LAST: begin
            item_in  = mem_rdata;
            pos_in   = '0;
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (left_idx >= count_wide) begin
               mem_we   = (count_ff != '0);
               state_in = ST_FIN;
            end else begin
               mem_raddr = left_idx[AW-1:0];
               state_in  = ST_DN_RDR;
            end
         end
         ST_DN_RDR: begin
            left_in = mem_rdata;
            if (right_ok) begin
               mem_raddr = right_idx[AW-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (pick.key < item_ff.key) begin
               // Move the smaller child up into the hole.
               mem_wdata = pick;
               pos_in    = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
               state_in  = ST_DN_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in       = res_ff;
               rsp_data_in.count = 8'(count_ff);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      item_ff     <= item_in;
      left_ff     <= left_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall,
      "accepted item did not hold the input stalled")
   `ASSERT_IMPL(a_write_below_count, clock, reset, mem_we, IW'(mem_waddr) < count_wide,
      "heap write beyond item count")
   `ASSERT_IMPL(a_full_only_at_capacity, clock, reset,
      (state_ff == ST_FIN) && (res_ff.status == STATUS_FULL), count_ff == CW'(CAPACITY),
      "full status below capacity")
   `ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1, count_wide <= IW'(CAPACITY),
      "item count above capacity")

endmodule

### src/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/heap_result_checker.sv
// Checker for the heap queue: predicts each result from accepted items and compares.
`timescale 1ns / 1ps

module heap_result_checker
   import hpq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   entry_type heap_mem [CAPACITY];
   int        held = 0;
   rsp_type   awaited_rsp [$];
   int        mismatches = 0;
   int        awaited_n = 0;

   assign fail_count    = mismatches;
   assign pending_count = awaited_n;

   task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Apply one operation to the shadow heap and return the result it should produce.
   function automatic rsp_type heap_apply(req_type item);
      rsp_type   res;
      entry_type tmp;
      int        pos;
      int        parent;
      int        left;
      int        right;
      int        pick;
      res = '0;
      if (item.kind == KIND_INSERT) begin
         if (held >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            heap_mem[held] = '{key: item.key, payload: item.payload};
            pos = held;
            held++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (heap_mem[pos].key < heap_mem[parent].key) begin
                  tmp = heap_mem[pos];
                  heap_mem[pos] = heap_mem[parent];
                  heap_mem[parent] = tmp;
                  pos = parent;
               end else begin
                  break;
               end
            end
         end
      end else begin
         if (held == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.out_key     = heap_mem[0].key;
            res.out_payload = heap_mem[0].payload;
            held--;
            heap_mem[0] = heap_mem[held];
            pos = 0;
            while (1) begin
               left  = 2 * pos + 1;
               right = left + 1;
               if (left >= held) break;
               // right child wins ties
               if (right < held && !(heap_mem[left].key < heap_mem[right].key))
                  pick = right;
               else
                  pick = left;
               if (heap_mem[pick].key < heap_mem[pos].key) begin
                  tmp = heap_mem[pos];
                  heap_mem[pos] = heap_mem[pick];
                  heap_mem[pick] = tmp;
                  pos = pick;
               end else begin
                  break;
               end
            end
         end
      end
      res.count = 8'(held);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         // compare first so a result never meets the item accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               note_mismatch("result with none awaited", 32'(rsp_data.status), 0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  note_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.out_key !== want.out_key)
                  note_mismatch("out_key", rsp_data.out_key, want.out_key);
               if (rsp_data.out_payload !== want.out_payload)
                  note_mismatch("out_payload", 32'(rsp_data.out_payload),
                                32'(want.out_payload));
               if (rsp_data.count !== want.count)
                  note_mismatch("count", 32'(rsp_data.count), 32'(want.count));
            end
         end
         if (req_valid && !req_stall) awaited_rsp.push_back(heap_apply(req_data));
      end
      awaited_n <= awaited_rsp.size();
   end

endmodule

### tb/binary_min_heap_priority_queue_unit_tb.sv
// Testbench top for the heap queue: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_unit_tb;
   import hpq_pkg::*;

   localparam int CAPACITY       = 128;
   localparam int RANDOM_ITEMS   = 1230;
   localparam int PHASE_LEN      = 200;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    calm      = 1'b0;
   int      fail_count;
   int      pending_count;
   int      quiet_cycles = 0;

   always #4 clock = ~clock;

   binary_min_heap_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   heap_result_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, after a random gap unless calm, and hold it until accepted.
   task automatic offer_item(logic kind, logic [31:0] key, logic [15:0] payload);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, key: key, payload: payload};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Many small keys so that equal keys are common, plus extremes and full-range values.
   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return 32'($urandom_range(15));
      if (sel == 4) begin
         case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   initial begin : stimulus
      int insert_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty remove, extreme keys and payloads, equal keys, drain past empty
      offer_item(KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      offer_item(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      offer_item(KIND_INSERT, 32'h0000_0000, 16'h0000);
      offer_item(KIND_INSERT, 32'd5, 16'hAAAA);
      offer_item(KIND_INSERT, 32'd5, 16'h5555);
      offer_item(KIND_INSERT, 32'd5, 16'h1234);
      offer_item(KIND_INSERT, 32'h8000_0000, 16'h8000);
      offer_item(KIND_INSERT, 32'h0000_0000, 16'h0001);
      offer_item(KIND_INSERT, 32'd1, 16'h0002);
      repeat (9) offer_item(KIND_REMOVE, $urandom, 16'($urandom));
      offer_item(KIND_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
      offer_item(KIND_REMOVE, 32'h0, 16'h0);
      wait_for_results();

      // random: alternate filling past full, draining past empty, and a balanced mix
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ((i / PHASE_LEN) % 3)
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 55;
         endcase
         if (i == 400) wait_for_results();
         if (i == 600) calm <= 1'b1;
         if (i == 800) calm <= 1'b0;
         if ($urandom_range(99) < insert_pct)
            offer_item(KIND_INSERT, pick_key(), 16'($urandom));
         else
            offer_item(KIND_REMOVE, $urandom, 16'($urandom));
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/hpq_pkg.sv
src/hpq_ram.sv
src/binary_min_heap_priority_queue_unit.sv
tb/heap_result_checker.sv
tb/binary_min_heap_priority_queue_unit_tb.sv
